// ===== rtl/srmd_pkg.sv =====
// Shared types, constants and word-building helpers for the scrolling RGB matrix driver.
package srmd_pkg;

  localparam int unsigned MAX_ROW_BYTES = 16;
  localparam int unsigned MATRIX_ROWS   = 8;
  localparam int unsigned ROW_AW        = $clog2(MATRIX_ROWS);
  localparam int unsigned COL_AW        = $clog2(MAX_ROW_BYTES);
  localparam int unsigned MEM_DEPTH     = MATRIX_ROWS * MAX_ROW_BYTES;
  localparam int unsigned MEM_AW        = $clog2(MEM_DEPTH);

  localparam logic [7:0] CH_RED   = 8'b00000001;
  localparam logic [7:0] CH_GREEN = 8'b00000010;
  localparam logic [7:0] CH_BLUE  = 8'b00000100;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_REFRESH = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef enum logic {
    REG_ROW_BYTES   = 1'b0,
    REG_BIT_COLUMNS = 1'b1
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] row;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic [2:0]  row_index;
    logic        last_row;
  } out_beat_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) begin
      r[7-b] = v[b];
    end
    return r;
  endfunction

  function automatic logic [7:0] colour_sel(input logic [1:0] colour);
    logic [7:0] sel;
    case (colour)
      2'd0:    sel = CH_RED;
      2'd1:    sel = CH_GREEN;
      2'd2:    sel = CH_BLUE;
      default: sel = 8'h00;
    endcase
    return sel;
  endfunction

  // Assemble one shift chain word: row mask split around green, reversed red and blue.
  function automatic logic [31:0] make_word(input logic [2:0] row, input logic [1:0] colour,
                                            input logic [7:0] window);
    logic [7:0] mask;
    logic [7:0] sel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    mask  = 8'(1) << row;
    sel   = colour_sel(colour);
    red   = ~((sel & CH_RED)   != 8'h00 ? window : 8'h00);
    green = ~((sel & CH_GREEN) != 8'h00 ? window : 8'h00);
    blue  = ~((sel & CH_BLUE)  != 8'h00 ? window : 8'h00);
    return {mask[7:4], green, mask[3:0], rev8(red), rev8(blue)};
  endfunction

endpackage

// ===== rtl/scrolling_rgb_matrix_driver.sv =====
// Top level of the scrolling RGB matrix driver: command decode, row sequencer, output register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | sink      | in_valid_i / in_ready_o | in_data_i  (opcode,row,index,byte)
//   out     | source    | out_valid_o/out_ready_i | out_data_o (frame,row_index,last)
//   cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A write or advance beat completes without leaving the idle state. A refresh beat issues one read pair
// per row from the bitmap RAM's two read ports; with the output ready this gives eight words
// back to back, each row passing the sequencer, the registered RAM read and the single output
// register in that order.
// Reset clears the sequencer, scroll offset, colour and the RAM valid bits at once.
// A stalled output holds the output register, then the read stage, then the issue counter.
module scrolling_rgb_matrix_driver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srmd_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srmd_pkg::out_beat_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);

  // Configuration registers.
  logic [4:0] row_bytes_q;
  logic [7:0] bit_columns_q;

  // Scroll state.
  logic [6:0] offset_q, offset_d;
  logic [1:0] colour_q, colour_d;

  // Sequencer.
  srmd_pkg::state_e            state_q, state_d;
  logic [srmd_pkg::ROW_AW-1:0] iss_row_q, iss_row_d;

  // Read stage: RAM data is valid for rd_row_q.
  logic                        rd_valid_q, rd_valid_d;
  logic [srmd_pkg::ROW_AW-1:0] rd_row_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  srmd_pkg::out_beat_t out_q;

  logic in_fire;
  logic issue;
  logic load_out;

  logic                        mem_we;
  logic [srmd_pkg::MEM_AW-1:0] mem_waddr;
  logic [srmd_pkg::MEM_AW-1:0] raddr_a;
  logic [srmd_pkg::MEM_AW-1:0] raddr_b;
  logic                        ren_a;
  logic                        ren_b;
  logic [7:0]                  rdata_a;
  logic [7:0]                  rdata_b;

  logic [3:0]  byte_q;
  logic [4:0]  byte_next;
  logic [4:0]  lim;
  logic [2:0]  bit_shift;
  logic [15:0] pair_shifted;
  logic [7:0]  window;

  logic [7:0] limit;
  logic [7:0] offset_next;

  assign in_ready_o = (state_q == srmd_pkg::ST_IDLE) && !rd_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  assign load_out = rd_valid_q && (!out_valid_q || out_ready_i);
  assign issue    = (state_q == srmd_pkg::ST_RUN) && (!rd_valid_q || load_out);

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= 5'd1;
      bit_columns_q <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srmd_pkg::REG_ROW_BYTES:   row_bytes_q   <= cfg_data_i[4:0];
        srmd_pkg::REG_BIT_COLUMNS: bit_columns_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Bitmap writes go straight to the RAM; the index always lies inside a row.
  // ---------------------------------------------------------------------------
  assign mem_we    = in_fire && (in_data_i.opcode == srmd_pkg::OP_WRITE);
  assign mem_waddr = {in_data_i.row, in_data_i.byte_index};

  // ---------------------------------------------------------------------------
  // Scroll advance: wrap limit is bit_columns - 7, at least 1, at most 128.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (bit_columns_q >= 8'd8) begin
      limit = bit_columns_q - 8'd7;
    end else begin
      limit = 8'd1;
    end
    if (limit > 8'd128) begin
      limit = 8'd128;
    end
    offset_next = {1'b0, offset_q} + 8'd1;

    offset_d = offset_q;
    colour_d = colour_q;
    if (in_fire && (in_data_i.opcode == srmd_pkg::OP_ADVANCE)) begin
      if (offset_next >= limit) begin
        offset_d = '0;
        colour_d = (colour_q >= 2'd2) ? 2'd0 : colour_q + 2'd1;
      end else begin
        offset_d = offset_next[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      colour_q <= '0;
    end else begin
      offset_q <= offset_d;
      colour_q <= colour_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Row sequencer: step through the eight rows, one read pair per row.
  // Offset and colour cannot change while it runs, since input is blocked.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srmd_pkg::ST_IDLE;
      iss_row_q <= '0;
    end else begin
      state_q   <= state_d;
      iss_row_q <= iss_row_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    iss_row_d = iss_row_q;
    case (state_q)
      srmd_pkg::ST_IDLE: begin
        if (in_fire && (in_data_i.opcode == srmd_pkg::OP_REFRESH)) begin
          state_d   = srmd_pkg::ST_RUN;
          iss_row_d = '0;
        end
      end
      srmd_pkg::ST_RUN: begin
        if (issue) begin
          iss_row_d = iss_row_q + 1'b1;
          if (iss_row_q == srmd_pkg::ROW_AW'(srmd_pkg::MATRIX_ROWS - 1)) begin
            state_d = srmd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = srmd_pkg::ST_IDLE;
      end
    endcase
  end

  // Window spans byte q and byte q+1; bytes at or beyond the row length read as zero.
  assign byte_q    = offset_q[6:3];
  assign byte_next = {1'b0, byte_q} + 5'd1;
  assign lim       = (row_bytes_q > 5'(srmd_pkg::MAX_ROW_BYTES))
                   ? 5'(srmd_pkg::MAX_ROW_BYTES) : row_bytes_q;
  assign ren_a     = {1'b0, byte_q} < lim;
  assign ren_b     = byte_next < lim;
  assign raddr_a   = {iss_row_q, byte_q};
  assign raddr_b   = {iss_row_q, byte_next[srmd_pkg::COL_AW-1:0]};

  srmd_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (in_data_i.byte_value),
    .re_i      (issue),
    .raddr_a_i (raddr_a),
    .ren_a_i   (ren_a),
    .raddr_b_i (raddr_b),
    .ren_b_i   (ren_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // ---------------------------------------------------------------------------
  // Read stage tracking
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_valid_d = rd_valid_q;
    if (issue) begin
      rd_valid_d = 1'b1;
    end else if (load_out) begin
      rd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_row_q <= iss_row_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Window extract and output register
  // ---------------------------------------------------------------------------
  assign bit_shift    = offset_q[2:0];
  assign pair_shifted = {rdata_a, rdata_b} << bit_shift;
  assign window       = pair_shifted[15:8];

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.frame_word <= srmd_pkg::make_word(rd_row_q, colour_q, window);
      out_q.row_index  <= rd_row_q;
      out_q.last_row   <= (rd_row_q == srmd_pkg::ROW_AW'(srmd_pkg::MATRIX_ROWS - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/srmd_bitmap_ram.sv =====
// Bitmap store: one write port, two registered read ports, per-entry valid bits.
module srmd_bitmap_ram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [srmd_pkg::MEM_AW-1:0] waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic                       re_i,
  input  logic [srmd_pkg::MEM_AW-1:0] raddr_a_i,
  input  logic                       ren_a_i,
  input  logic [srmd_pkg::MEM_AW-1:0] raddr_b_i,
  input  logic                       ren_b_i,
  output logic [7:0]                 rdata_a_o,
  output logic [7:0]                 rdata_b_o
);

  logic [7:0]                     mem [srmd_pkg::MEM_DEPTH];
  logic [srmd_pkg::MEM_DEPTH-1:0] valid_q;
  logic [7:0]                     rdata_a_q;
  logic [7:0]                     rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= (ren_a_i && valid_q[raddr_a_i]) ? mem[raddr_a_i] : 8'h00;
      rdata_b_q <= (ren_b_i && valid_q[raddr_b_i]) ? mem[raddr_b_i] : 8'h00;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== test/tb_scrolling_rgb_matrix_driver.sv =====
// Self-checking testbench for the scrolling RGB matrix driver: commands in, row words out.
module tb_scrolling_rgb_matrix_driver;

  // Size the limit for the slowest correct run: about 420 beats, each up to eight words,
  // each word behind the longest ready stall, plus sender gaps and settling at every phase.
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  // Let a refresh that is still in flight finish before touching the registers.
  localparam int unsigned SETTLE_CYCLES = 12;
  // The scroll offset is 7 bits wide, so the wrap point never exceeds its span.
  localparam int unsigned OFFSET_SPAN   = 128;
  localparam int unsigned SHADOW_DEPTH  = srmd_pkg::MATRIX_ROWS * srmd_pkg::MAX_ROW_BYTES;

  // Opcode with no meaning; the block must drop it without a word.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    HUE_RED   = 2'd0,
    HUE_GREEN = 2'd1,
    HUE_BLUE  = 2'd2,
    HUE_OFF   = 2'd3
  } hue_e;

  // Block ports; the inputs are driven to known values from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cmd_valid   = 1'b0;
  logic                cmd_ready;
  srmd_pkg::in_beat_t  cmd_beat    = '0;
  logic                frame_valid;
  logic                frame_ready = 1'b0;
  srmd_pkg::out_beat_t frame_beat;
  logic                cfg_we      = 1'b0;
  logic                cfg_idx     = srmd_pkg::REG_ROW_BYTES;
  logic [7:0]          cfg_data    = '0;

  // Shadow of the block state, kept in step with every accepted command beat.
  logic [7:0] pixel_shadow [SHADOW_DEPTH];
  logic [6:0] offset_shadow    = '0;
  hue_e       hue_shadow       = HUE_RED;
  logic [4:0] row_bytes_shadow = 5'd1;
  logic [7:0] columns_shadow   = 8'd8;

  // Pending command beats and the row words they must produce, oldest first.
  srmd_pkg::in_beat_t  cmd_backlog [$];
  srmd_pkg::out_beat_t frames_due [$];

  int unsigned cmds_issued    = 0;
  int unsigned beats_driven   = 0;
  int unsigned beats_accepted = 0;
  int unsigned words_seen     = 0;
  int unsigned words_taken    = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned reg_writes     = 0;
  int unsigned cmd_gap_left   = 0;
  int unsigned stall_left     = 0;
  int unsigned cmd_gap_max    = 10;
  int unsigned stall_max      = 10;

  scrolling_rgb_matrix_driver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_valid),
    .in_ready_o  (cmd_ready),
    .in_data_i   (cmd_beat),
    .out_valid_o (frame_valid),
    .out_ready_i (frame_ready),
    .out_data_o  (frame_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] mirror_byte(input logic [7:0] v);
    logic [7:0] r;
    int         b;
    for (b = 0; b < 8; b++) begin
      r[b] = v[7-b];
    end
    return r;
  endfunction

  // Read one bitmap byte as the window sees it: past the row width it is blank.
  function automatic logic [7:0] stored_byte(input logic [2:0] row, input int unsigned pos);
    int unsigned span;
    span = (row_bytes_shadow < srmd_pkg::MAX_ROW_BYTES)
         ? row_bytes_shadow : srmd_pkg::MAX_ROW_BYTES;
    if (pos >= span) begin
      return 8'h00;
    end
    return pixel_shadow[row * srmd_pkg::MAX_ROW_BYTES + pos];
  endfunction

  // Build the shift chain word for one row; colour bytes are active low and only
  // the current hue carries the window.
  function automatic srmd_pkg::out_beat_t frame_for_row(input logic [2:0] row,
                                                        input logic [7:0] window);
    logic [7:0]          mask;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    srmd_pkg::out_beat_t w;
    mask  = 8'd1 << row;
    red   = 8'hFF;
    green = 8'hFF;
    blue  = 8'hFF;
    case (hue_shadow)
      HUE_RED: begin
        red = ~window;
      end
      HUE_GREEN: begin
        green = ~window;
      end
      HUE_BLUE: begin
        blue = ~window;
      end
      default: begin
      end
    endcase
    w.frame_word = {mask[7:4], green, mask[3:0], mirror_byte(red), mirror_byte(blue)};
    w.row_index  = row;
    w.last_row   = (row == 3'd7);
    return w;
  endfunction

  // Advance the shadow by one accepted beat and queue the words it must cause.
  task automatic apply_command(input srmd_pkg::in_beat_t c);
    int unsigned q;
    int unsigned r;
    int unsigned wrap_at;
    int unsigned nxt;
    int unsigned i;
    logic [7:0]  window;
    logic [2:0]  row;
    case (c.opcode)
      srmd_pkg::OP_WRITE: begin
        pixel_shadow[{c.row, c.byte_index}] = c.byte_value;
      end
      srmd_pkg::OP_REFRESH: begin
        q = offset_shadow >> 3;
        r = offset_shadow & 7;
        for (i = 0; i < srmd_pkg::MATRIX_ROWS; i++) begin
          row    = 3'(i);
          window = stored_byte(row, q) << r;
          // An aligned offset takes exactly one byte; otherwise splice in the next one.
          if (r != 0) begin
            window = window | (stored_byte(row, q + 1) >> (8 - r));
          end
          frames_due.push_back(frame_for_row(row, window));
        end
      end
      srmd_pkg::OP_ADVANCE: begin
        wrap_at = (columns_shadow >= 8) ? columns_shadow - 7 : 1;
        if (wrap_at > OFFSET_SPAN) begin
          wrap_at = OFFSET_SPAN;
        end
        nxt = offset_shadow + 1;
        // Also wraps an offset left past the limit by a register change.
        if (nxt >= wrap_at) begin
          offset_shadow = '0;
          hue_shadow    = (hue_shadow >= HUE_BLUE) ? HUE_RED : hue_e'(hue_shadow + 2'd1);
        end else begin
          offset_shadow = 7'(nxt);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    // Cap the log; the count keeps going.
    if (mismatches <= 100) begin
      $display("mismatch at cycle %0d, word %0d: %s got %h want %h",
               cycle_count, words_seen, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: change at the falling edge, hold each beat until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : cmd_driver
    logic               nxt_valid;
    srmd_pkg::in_beat_t nxt_beat;
    if (rst_ni) begin
      nxt_valid = cmd_valid;
      nxt_beat  = cmd_beat;
      // The beat on the bus was taken at the last rising edge.
      if (cmd_valid && beats_accepted == beats_driven) begin
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (cmd_gap_left > 0) begin
          cmd_gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          nxt_beat     = cmd_backlog.pop_front();
          nxt_valid    = 1'b1;
          beats_driven++;
          cmd_gap_left = $urandom_range(0, cmd_gap_max);
        end
      end
      // One assignment per step, so a back-to-back beat never drops valid.
      cmd_valid <= nxt_valid;
      cmd_beat  <= nxt_beat;
    end
  end

  // Word sink: after each word taken, stall ready for a drawn number of cycles.
  always @(negedge clk_i) begin : frame_sink
    if (rst_ni) begin
      if (words_seen != words_taken) begin
        words_taken = words_seen;
        stall_left  = $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        frame_ready <= 1'b0;
      end else begin
        frame_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check the word first, then
  // record the command, so a queue push and pop never race.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    srmd_pkg::out_beat_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words still due",
               cycle_count, frames_due.size());
      $display("TEST FAILED");
      $finish;
    end else if (rst_ni) begin
      if (frame_valid && frame_ready) begin
        words_seen++;
        if (frames_due.size() == 0) begin
          report_mismatch("word with none due", frame_beat.frame_word, 32'h0);
        end else begin
          want = frames_due.pop_front();
          if (frame_beat.frame_word !== want.frame_word) begin
            report_mismatch("frame_word", frame_beat.frame_word, want.frame_word);
          end
          if (frame_beat.row_index !== want.row_index) begin
            report_mismatch("row_index", 32'(frame_beat.row_index), 32'(want.row_index));
          end
          if (frame_beat.last_row !== want.last_row) begin
            report_mismatch("last_row", 32'(frame_beat.last_row), 32'(want.last_row));
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        apply_command(cmd_beat);
        beats_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_cmd(input logic [1:0] op, input logic [2:0] row,
                          input logic [3:0] idx, input logic [7:0] value);
    srmd_pkg::in_beat_t c;
    c.opcode     = op;
    c.row        = row;
    c.byte_index = idx;
    c.byte_value = value;
    cmd_backlog.push_back(c);
    cmds_issued++;
  endtask

  // Hold until every beat is taken and every word has come, then let the block settle.
  task automatic drain();
    while (beats_accepted != cmds_issued || frames_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it into the shadow.
  task automatic set_reg(input srmd_pkg::reg_e which, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= which;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (which == srmd_pkg::REG_ROW_BYTES) begin
      row_bytes_shadow = value[4:0];
    end else begin
      columns_shadow = value;
    end
    reg_writes++;
  endtask

  // Drain, reprogram, then queue a random mix weighted toward advances by adv_pct.
  task automatic random_phase(input int unsigned rows, input int unsigned cols,
                              input int unsigned count, input int unsigned adv_pct,
                              input int unsigned gap, input int unsigned stall);
    int unsigned n;
    int unsigned pick;
    logic [1:0]  op;
    drain();
    set_reg(srmd_pkg::REG_ROW_BYTES, 8'(rows));
    set_reg(srmd_pkg::REG_BIT_COLUMNS, 8'(cols));
    cmd_gap_max = gap;
    stall_max   = stall;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        op = OP_UNUSED;
      end else if (pick < 5 + adv_pct) begin
        op = srmd_pkg::OP_ADVANCE;
      end else if (pick < 25 + adv_pct) begin
        op = srmd_pkg::OP_REFRESH;
      end else begin
        op = srmd_pkg::OP_WRITE;
      end
      push_cmd(op, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
               8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    for (i = 0; i < SHADOW_DEPTH; i++) begin
      pixel_shadow[i] = 8'h00;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset registers: one byte per row, eight columns, so every advance wraps.
    push_cmd(srmd_pkg::OP_REFRESH, 3'd0, 4'd0, 8'h00);     // store comes up blank
    push_cmd(srmd_pkg::OP_WRITE,   3'd0, 4'd0, 8'hFF);
    push_cmd(srmd_pkg::OP_WRITE,   3'd7, 4'd0, 8'h81);
    push_cmd(srmd_pkg::OP_WRITE,   3'd3, 4'd15, 8'hA5);    // beyond the row width for now
    push_cmd(srmd_pkg::OP_WRITE,   3'd4, 4'd0, 8'h01);
    push_cmd(OP_UNUSED,            3'd7, 4'd15, 8'hFF);    // must change nothing
    push_cmd(srmd_pkg::OP_REFRESH, 3'd7, 4'd15, 8'hFF);
    push_cmd(srmd_pkg::OP_ADVANCE, 3'd0, 4'd0, 8'h00);     // red to green
    push_cmd(srmd_pkg::OP_REFRESH, 3'd0, 4'd0, 8'h00);
    push_cmd(srmd_pkg::OP_ADVANCE, 3'd0, 4'd0, 8'h00);     // green to blue
    push_cmd(srmd_pkg::OP_REFRESH, 3'd0, 4'd0, 8'h00);
    push_cmd(srmd_pkg::OP_ADVANCE, 3'd0, 4'd0, 8'h00);     // blue back to red
    push_cmd(srmd_pkg::OP_REFRESH, 3'd0, 4'd0, 8'h00);

    // Directed, widest rows: unaligned window spanning two bytes, then aligned.
    drain();
    set_reg(srmd_pkg::REG_ROW_BYTES, 8'd16);
    set_reg(srmd_pkg::REG_BIT_COLUMNS, 8'd128);
    push_cmd(srmd_pkg::OP_WRITE, 3'd2, 4'd0, 8'h0F);
    push_cmd(srmd_pkg::OP_WRITE, 3'd2, 4'd1, 8'hF0);
    push_cmd(srmd_pkg::OP_WRITE, 3'd6, 4'd1, 8'h3C);
    push_cmd(srmd_pkg::OP_WRITE, 3'd6, 4'd2, 8'hC3);
    repeat (3) push_cmd(srmd_pkg::OP_ADVANCE, 3'd0, 4'd0, 8'h00);
    push_cmd(srmd_pkg::OP_REFRESH, 3'd0, 4'd0, 8'h00);
    repeat (5) push_cmd(srmd_pkg::OP_ADVANCE, 3'd0, 4'd0, 8'h00);
    push_cmd(srmd_pkg::OP_REFRESH, 3'd0, 4'd0, 8'h00);

    // Random phases. The first climbs the offset under a saturated wrap limit; the
    // second shrinks the limit below it, so the next advance must wrap.
    random_phase(16, 255, 60, 60, 10, 10);
    random_phase(4, 20, 40, 25, 0, 0);           // no idling on either side
    random_phase(0, 8, 40, 25, 10, 10);          // zero row width, blank window
    random_phase(31, 135, 50, 30, 10, 0);
    random_phase(2, 3, 40, 25, 0, 10);           // narrow bitmap, every advance wraps
    random_phase($urandom_range(1, 16), $urandom_range(8, 128), 60, 30, 10, 10);
    random_phase(16, 128, 60, 45, 3, 10);
    random_phase(1, 0, 40, 25, 10, 10);

    drain();
    $display("ran %0d command beats and checked %0d row words", beats_accepted, words_seen);
    $display("across %0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
